FILE: hw/rtl/string_to_integer_parser_assert.svh
// ---------------------------------------------------------------------------
// String-to-integer parser assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STIP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define STIP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STIP_ASSERT_IMP(label, ante, cons, msg)
`define STIP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/stip_pkg.sv
// ---------------------------------------------------------------------------
// stip_pkg
// Types and character constants of the string-to-integer parser.
// ---------------------------------------------------------------------------
package stip_pkg;

   localparam int ACC_W   = 64;
   localparam int RADIX_W = 6;
   localparam int PROD_W  = ACC_W + RADIX_W;
   localparam int OFS_W   = 16;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA_BASE = CH_UA - 8'd10;
   localparam logic [7:0] CH_LA_BASE = CH_LA - 8'd10;
   localparam logic [7:0] NO_DIGIT = 8'hFF;

   localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

   localparam logic [ACC_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [OFS_W-1:0] OFS_MAX   = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_DONE   = 3'd0,
      PH_LEAD   = 3'd1,
      PH_SIGNED = 3'd2,
      PH_ZERO   = 3'd3,
      PH_DIGITS = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0]         ch;
      logic               first;
      logic [RADIX_W-1:0] base;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic [OFS_W-1:0]        end_offset;
      logic                    overflow;
      logic                    got_digits;
   } rsp_type;

   typedef struct packed {
      phase_type          phase;
      logic               negative;
      logic [RADIX_W-1:0] radix;
      logic [ACC_W-1:0]   accum;
      logic               overflowed;
      logic               seen_digit;
   } ctx_type;

   function automatic logic [7:0] digit_of(input logic [7:0] ch);
      logic [7:0] d;
      d = NO_DIGIT;
      if (ch >= CH_ZERO && ch <= CH_NINE) d = ch - CH_ZERO;
      else if (ch >= CH_UA && ch <= CH_UZ) d = ch - CH_UA_BASE;
      else if (ch >= CH_LA && ch <= CH_LZ) d = ch - CH_LA_BASE;
      return d;
   endfunction

endpackage

FILE: hw/rtl/stip_step.sv
// ---------------------------------------------------------------------------
// stip_step
// One character step: prefix/sign handling, digit accumulate with overflow
// detect, and result formatting on the terminating character.
// ---------------------------------------------------------------------------
module stip_step #(
   parameter int POS_BITS = 16
) (
   input  stip_pkg::req_type      item,
   input  stip_pkg::ctx_type      ctx,
   input  logic [POS_BITS-1:0]    pos,
   output stip_pkg::ctx_type      ctx_next,
   output logic [POS_BITS-1:0]    pos_next,
   output logic                   emit,
   output stip_pkg::rsp_type      result
);

   stip_pkg::ctx_type                 cur;
   stip_pkg::ctx_type                 pre;
   logic [POS_BITS-1:0]               cur_pos;
   logic                              take;
   logic [7:0]                        d_val;
   logic [stip_pkg::RADIX_W-1:0]      r_eff;
   logic [stip_pkg::PROD_W-1:0]       prod;
   logic [stip_pkg::ACC_W-1:0]        limit;
   logic [31:0]                       pos_wide;

   assign d_val = stip_pkg::digit_of(item.ch);

   // start of string resets context; then the prefix/sign decision
   always_comb begin
      cur     = ctx;
      cur_pos = pos;
      if (item.first) begin
         cur.phase      = stip_pkg::PH_LEAD;
         cur.negative   = 1'b0;
         cur.radix      = item.base;
         cur.accum      = '0;
         cur.overflowed = 1'b0;
         cur.seen_digit = 1'b0;
         cur_pos        = '0;
      end
      pre  = cur;
      take = 1'b0;
      unique case (cur.phase)
         stip_pkg::PH_LEAD, stip_pkg::PH_SIGNED: begin
            if (cur.phase == stip_pkg::PH_LEAD && item.ch == stip_pkg::CH_SPACE) begin
               pre.phase = stip_pkg::PH_LEAD;
            end else if (cur.phase == stip_pkg::PH_LEAD && item.ch == stip_pkg::CH_MINUS) begin
               pre.negative = 1'b1;
               pre.phase    = stip_pkg::PH_SIGNED;
            end else if (cur.phase == stip_pkg::PH_LEAD && item.ch == stip_pkg::CH_PLUS) begin
               pre.phase = stip_pkg::PH_SIGNED;
            end else if (item.ch == stip_pkg::CH_ZERO &&
                         (cur.radix == stip_pkg::RADIX_AUTO ||
                          cur.radix == stip_pkg::RADIX_HEX)) begin
               pre.phase = stip_pkg::PH_ZERO;
            end else begin
               if (cur.radix == stip_pkg::RADIX_AUTO) pre.radix = stip_pkg::RADIX_DEC;
               pre.phase = stip_pkg::PH_DIGITS;
               take      = 1'b1;
            end
         end
         stip_pkg::PH_ZERO: begin
            pre.phase = stip_pkg::PH_DIGITS;
            if (item.ch == stip_pkg::CH_LX || item.ch == stip_pkg::CH_UX) begin
               pre.radix = stip_pkg::RADIX_HEX;
            end else begin
               if (cur.radix == stip_pkg::RADIX_AUTO) pre.radix = stip_pkg::RADIX_OCT;
               pre.accum      = '0;
               pre.seen_digit = 1'b1;
               take           = 1'b1;
            end
         end
         stip_pkg::PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            pre.phase = stip_pkg::PH_DONE;
         end
      endcase
   end

   assign r_eff = (pre.radix == stip_pkg::RADIX_AUTO) ? stip_pkg::RADIX_DEC : pre.radix;
   assign limit = pre.negative ? stip_pkg::NEG_LIMIT : stip_pkg::POS_LIMIT;
   // accum never exceeds 2^63, so the product fits without wrap
   assign prod  = stip_pkg::PROD_W'(pre.accum) * stip_pkg::PROD_W'(r_eff)
                + stip_pkg::PROD_W'(d_val);
   assign pos_wide = 32'(cur_pos);

   always_comb begin
      ctx_next = pre;
      emit     = 1'b0;
      if (take) begin
         if (d_val >= 8'(r_eff)) begin
            emit           = 1'b1;
            ctx_next.phase = stip_pkg::PH_DONE;
         end else begin
            if (pre.overflowed || prod > stip_pkg::PROD_W'(limit))
               ctx_next.overflowed = 1'b1;
            else
               ctx_next.accum = prod[stip_pkg::ACC_W-1:0];
            ctx_next.seen_digit = 1'b1;
         end
      end

      pos_next = cur_pos;
      if (ctx_next.phase != stip_pkg::PH_DONE && !(&cur_pos))
         pos_next = cur_pos + 1'b1;

      if (pre.overflowed)
         result.value = $signed(limit);
      else if (pre.negative)
         result.value = $signed(stip_pkg::ACC_W'(0) - pre.accum);
      else
         result.value = $signed(pre.accum);
      if (!pre.seen_digit)
         result.end_offset = '0;
      else if (pos_wide > 32'(stip_pkg::OFS_MAX))
         result.end_offset = stip_pkg::OFS_MAX;
      else
         result.end_offset = pos_wide[stip_pkg::OFS_W-1:0];
      result.overflow   = pre.overflowed;
      result.got_digits = pre.seen_digit;
   end

endmodule

FILE: hw/rtl/string_to_integer_parser.sv
// ---------------------------------------------------------------------------
// string_to_integer_parser
// Streaming signed 64-bit integer parser, one character per request.
// ---------------------------------------------------------------------------
// A terminating character passes from the request register through the step
// unit into the result register, which holds rsp_valid high until rsp_ready.
// Throughput: one request per cycle; the step unit (64x6 multiply-add and
// limit compare) sits between the request register and the result register.
// A held result stalls the request register only, one entry deep.
// Reset: parser idle, characters ignored until a request with first set.
module string_to_integer_parser #(
   parameter int POS_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stip_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stip_pkg::rsp_type rsp_payload
);

`include "string_to_integer_parser_assert.svh"

   stip_pkg::req_type     in_ff;
   logic                  in_valid_ff, in_valid_in;
   stip_pkg::ctx_type     ctx_ff, ctx_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   stip_pkg::rsp_type     rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   stip_pkg::ctx_type     step_ctx;
   logic [POS_BITS-1:0]   step_pos;
   logic                  step_emit;
   stip_pkg::rsp_type     step_rsp;
   logic                  advance;

   stip_step #(.POS_BITS(POS_BITS)) u_step (
      .item     (in_ff),
      .ctx      (ctx_ff),
      .pos      (pos_ff),
      .ctx_next (step_ctx),
      .pos_next (step_pos),
      .emit     (step_emit),
      .result   (step_rsp)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;

      ctx_in = ctx_ff;
      pos_in = pos_ff;
      if (advance) begin
         ctx_in = step_ctx;
         pos_in = step_pos;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && step_emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)       rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         ctx_ff.phase       <= stip_pkg::PH_DONE;
         ctx_ff.negative    <= 1'b0;
         ctx_ff.radix       <= '0;
         ctx_ff.accum       <= '0;
         ctx_ff.overflowed  <= 1'b0;
         ctx_ff.seen_digit  <= 1'b0;
         pos_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctx_ff       <= ctx_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_payload;
      if (advance && step_emit)   rsp_ff <= step_rsp;
   end

   `STIP_ASSERT_NXT(a_emit_delivered, advance && step_emit, rsp_valid_ff, "result lost")
   `STIP_ASSERT_NXT(a_no_phantom, !rsp_valid_ff && !(advance && step_emit), !rsp_valid_ff, "unexpected result")
   `STIP_ASSERT_IMP(a_accum_range, 1'b1, ctx_ff.accum <= stip_pkg::NEG_LIMIT, "accumulator out of range")
   `STIP_ASSERT_IMP(a_no_digit_zero, rsp_valid_ff && !rsp_ff.got_digits, rsp_ff.value == 0 && rsp_ff.end_offset == 0 && !rsp_ff.overflow, "empty parse not zero")
   `STIP_ASSERT_IMP(a_sat_value, rsp_valid_ff && rsp_ff.overflow, rsp_ff.value == $signed(stip_pkg::POS_LIMIT) || rsp_ff.value == $signed(stip_pkg::NEG_LIMIT), "overflow not saturated")

endmodule

FILE: dv/string_to_integer_parser_tb.sv
// ---------------------------------------------------------------------------
// string_to_integer_parser_tb
// Streams character requests into the parser with random gaps on both
// channels, predicts every parse result in-bench and checks each result
// field by field in arrival order. Directed strings cover the number forms
// and corner cases, then a random phase mixes well-formed strings with
// noise, restarts and saturating values.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module string_to_integer_parser_tb;

   localparam int STUCK_LIMIT = 1000;
   localparam int QUIET_CYCLES = 10;
   localparam int ITEM_TARGET = 450;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   stip_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   stip_pkg::rsp_type rsp_payload;

   // parser state mirrored by the predictor
   stip_pkg::phase_type          prs_phase = stip_pkg::PH_DONE;
   logic                         prs_negative = 1'b0;
   logic [stip_pkg::RADIX_W-1:0] prs_radix = '0;
   logic [stip_pkg::ACC_W-1:0]   prs_accum = '0;
   logic                         prs_overflow = 1'b0;
   logic                         prs_seen = 1'b0;
   logic [stip_pkg::OFS_W-1:0]   prs_position = '0;

   stip_pkg::rsp_type expected_numbers[$];
   int          errors = 0;
   int unsigned chars_sent = 0;
   int unsigned chars_parsed = 0;
   int unsigned strings_sent = 0;
   int unsigned results_checked = 0;
   int unsigned saturated_results = 0;
   int unsigned stuck_cycles = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned rsp_stall = 0;
   bit          gaps_on = 1'b1;

   string_to_integer_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   function automatic int unsigned char_value(logic [7:0] c);
      if (c inside {[stip_pkg::CH_ZERO:stip_pkg::CH_NINE]}) return c - stip_pkg::CH_ZERO;
      if (c inside {[stip_pkg::CH_UA:stip_pkg::CH_UZ]}) return c - stip_pkg::CH_UA + 10;
      if (c inside {[stip_pkg::CH_LA:stip_pkg::CH_LZ]}) return c - stip_pkg::CH_LA + 10;
      return 255;
   endfunction

   function automatic void finish_string();
      stip_pkg::rsp_type num;
      if (prs_overflow)
         num.value = prs_negative ? stip_pkg::NEG_LIMIT : stip_pkg::POS_LIMIT;
      else
         num.value = prs_negative ? -prs_accum : prs_accum;
      num.end_offset = prs_seen ? prs_position : '0;
      num.overflow = prs_overflow;
      num.got_digits = prs_seen;
      expected_numbers.push_back(num);
      prs_phase = stip_pkg::PH_DONE;
   endfunction

   function automatic void take_digit(logic [7:0] c);
      logic [stip_pkg::ACC_W-1:0] d, rdx, lim, cutoff, cutlim;
      d = char_value(c);
      rdx = (prs_radix == stip_pkg::RADIX_AUTO) ? stip_pkg::ACC_W'(stip_pkg::RADIX_DEC)
                                                : stip_pkg::ACC_W'(prs_radix);
      if (d >= rdx) begin
         finish_string();
         return;
      end
      lim = prs_negative ? stip_pkg::NEG_LIMIT : stip_pkg::POS_LIMIT;
      cutoff = lim / rdx;
      cutlim = lim % rdx;
      // once saturated, digits are still eaten but the value stays pinned
      if (prs_overflow || prs_accum > cutoff || (prs_accum == cutoff && d > cutlim))
         prs_overflow = 1'b1;
      else
         prs_accum = prs_accum * rdx + d;
      prs_seen = 1'b1;
   endfunction

   function automatic void parse_char(stip_pkg::req_type r);
      if (r.first) begin
         prs_phase = stip_pkg::PH_LEAD;
         prs_negative = 1'b0;
         prs_radix = r.base;
         prs_accum = '0;
         prs_overflow = 1'b0;
         prs_seen = 1'b0;
         prs_position = '0;
      end
      case (prs_phase)
         stip_pkg::PH_LEAD, stip_pkg::PH_SIGNED: begin
            if (prs_phase == stip_pkg::PH_LEAD && r.ch == stip_pkg::CH_MINUS) begin
               prs_negative = 1'b1;
               prs_phase = stip_pkg::PH_SIGNED;
            end else if (prs_phase == stip_pkg::PH_LEAD && r.ch == stip_pkg::CH_PLUS) begin
               prs_phase = stip_pkg::PH_SIGNED;
            end else if (prs_phase == stip_pkg::PH_LEAD && r.ch == stip_pkg::CH_SPACE) begin
               // leading blank, skip
            end else if (r.ch == stip_pkg::CH_ZERO &&
                         (prs_radix == stip_pkg::RADIX_AUTO ||
                          prs_radix == stip_pkg::RADIX_HEX)) begin
               prs_phase = stip_pkg::PH_ZERO;
            end else begin
               if (prs_radix == stip_pkg::RADIX_AUTO) prs_radix = stip_pkg::RADIX_DEC;
               prs_phase = stip_pkg::PH_DIGITS;
               take_digit(r.ch);
            end
         end
         stip_pkg::PH_ZERO: begin
            prs_phase = stip_pkg::PH_DIGITS;
            if (r.ch == stip_pkg::CH_LX || r.ch == stip_pkg::CH_UX) begin
               prs_radix = stip_pkg::RADIX_HEX;
            end else begin
               if (prs_radix == stip_pkg::RADIX_AUTO) prs_radix = stip_pkg::RADIX_OCT;
               prs_seen = 1'b1;
               take_digit(r.ch);
            end
         end
         stip_pkg::PH_DIGITS: take_digit(r.ch);
         default: return;
      endcase
      chars_parsed++;
      if (prs_phase != stip_pkg::PH_DONE && prs_position != stip_pkg::OFS_MAX)
         prs_position++;
   endfunction

   // ---------------- checking ----------------

   function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      stip_pkg::rsp_type want;
      if (!reset && req_valid && req_ready) parse_char(req_payload);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_numbers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual value %0h",
                     $time, rsp_payload.value);
         end else begin
            want = expected_numbers.pop_front();
            compare_field("value", want.value, rsp_payload.value);
            compare_field("end_offset", want.end_offset, rsp_payload.end_offset);
            compare_field("overflow", want.overflow, rsp_payload.overflow);
            compare_field("got_digits", want.got_digits, rsp_payload.got_digits);
            results_checked++;
            if (rsp_payload.overflow) saturated_results++;
         end
      end
   end

   // ---------------- result side ----------------

   function automatic int unsigned pick_gap();
      return gaps_on ? $urandom_range(8, 0) : 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_stall = pick_gap();
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, STUCK_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------- request side ----------------

   // valid is left high after acceptance so a back-to-back request needs one NBA only
   task automatic send_char(logic [7:0] c, logic is_first, logic [stip_pkg::RADIX_W-1:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{ch: c, first: is_first, base: b};
      if (is_first) strings_sent++;
      chars_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_string(string s, logic [stip_pkg::RADIX_W-1:0] b);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == 0,
                   (i == 0) ? b : stip_pkg::RADIX_W'($urandom_range(63, 0)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_numbers.size() != 0) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_ignored_after_reset();
      send_char(stip_pkg::CH_UA, 1'b0, stip_pkg::RADIX_HEX);
      send_char(8'hFF, 1'b0, stip_pkg::RADIX_AUTO);
      send_char(stip_pkg::CH_NINE, 1'b0, stip_pkg::RADIX_DEC);
      wait_drained();
   endtask

   task automatic test_number_forms();
      send_string(" -12", stip_pkg::RADIX_DEC);
      send_char(8'h00, 1'b0, stip_pkg::RADIX_DEC);
      send_string("+zZ", 6'd63);
      send_char(8'hFF, 1'b0, 6'd63);
      send_string("017;", stip_pkg::RADIX_AUTO);
      send_string("0x1fg", stip_pkg::RADIX_AUTO);
      send_string("0XA.", stip_pkg::RADIX_HEX);
      wait_drained();
   endtask

   task automatic test_special_cases();
      send_string("0x;", stip_pkg::RADIX_AUTO);   // bare prefix
      send_string("0Xg", stip_pkg::RADIX_HEX);
      send_string("0z", stip_pkg::RADIX_HEX);     // zero without x
      send_string("09", stip_pkg::RADIX_AUTO);    // zero then 9 under octal
      send_string("01", 6'd1);                    // radix 1 takes only zeros
      send_string("Z!", 6'd37);
      send_string("- 5", stip_pkg::RADIX_DEC);    // no blanks after a sign
      send_string(";", stip_pkg::RADIX_DEC);
      send_string("12", stip_pkg::RADIX_DEC);     // abandoned by the next start
      send_string("34;", stip_pkg::RADIX_DEC);
      send_char(stip_pkg::CH_NINE, 1'b0, stip_pkg::RADIX_DEC);
      wait_drained();
   endtask

   task automatic test_saturation();
      send_string("zzzzzzzzzzzz.", 6'd63);
      send_string("-zzzzzzzzzzzz.", 6'd63);
      send_string("-0x8000000000000000 ", stip_pkg::RADIX_AUTO);
      send_string("0x8000000000000000 ", stip_pkg::RADIX_AUTO);
      send_string("9223372036854775807,", stip_pkg::RADIX_DEC);
      wait_drained();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 30; i++) begin
         send_char(stip_pkg::CH_ZERO + 8'(i % 10), 1'b1, stip_pkg::RADIX_DEC);
         send_char(stip_pkg::CH_PLUS, 1'b0, stip_pkg::RADIX_DEC);
      end
      wait_drained();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_strings();
      logic [7:0]                   chars[$];
      logic [7:0]                   c;
      logic [stip_pkg::RADIX_W-1:0] b;
      int unsigned                  eff, dmax, n, v;
      while (chars_sent < ITEM_TARGET) begin
         chars.delete();
         gaps_on = ($urandom_range(4, 0) != 0);
         case ($urandom_range(7, 0))
            0, 1:    b = stip_pkg::RADIX_AUTO;
            2:       b = stip_pkg::RADIX_OCT;
            3:       b = stip_pkg::RADIX_DEC;
            4:       b = stip_pkg::RADIX_HEX;
            5:       b = 6'd2;
            6:       b = 6'd36;
            default: b = stip_pkg::RADIX_W'($urandom_range(63, 0));
         endcase
         if ($urandom_range(99, 0) < 15) begin
            repeat ($urandom_range(6, 1)) chars.push_back(8'($urandom_range(255, 0)));
         end else begin
            if ($urandom_range(3, 0) == 0)
               repeat ($urandom_range(3, 1)) chars.push_back(stip_pkg::CH_SPACE);
            case ($urandom_range(3, 0))
               0: chars.push_back(stip_pkg::CH_MINUS);
               1: chars.push_back(stip_pkg::CH_PLUS);
               default: ;
            endcase
            eff = b;
            if (b == stip_pkg::RADIX_AUTO || b == stip_pkg::RADIX_HEX) begin
               case ($urandom_range(2, 0))
                  0: begin
                     chars.push_back(stip_pkg::CH_ZERO);
                     chars.push_back($urandom_range(1, 0) ? stip_pkg::CH_LX
                                                          : stip_pkg::CH_UX);
                     eff = stip_pkg::RADIX_HEX;
                  end
                  1: if (b == stip_pkg::RADIX_AUTO) begin
                     chars.push_back(stip_pkg::CH_ZERO);
                     eff = stip_pkg::RADIX_OCT;
                  end
                  default: ;
               endcase
            end
            if (eff == 0) eff = stip_pkg::RADIX_DEC;
            dmax = (eff > 36) ? 36 : eff;
            // some strings run long enough to cross the 64-bit limit
            if (eff > 1 && $urandom_range(3, 0) == 0)
               n = $urandom_range(64 / ($clog2(eff + 1) - 1) + 2, 1);
            else
               n = $urandom_range(5, 1);
            repeat (n) begin
               v = $urandom_range(dmax - 1, 0);
               c = (v < 10) ? 8'(stip_pkg::CH_ZERO + v)
                            : 8'(($urandom_range(1, 0) ? stip_pkg::CH_UA
                                                       : stip_pkg::CH_LA) + v - 10);
               chars.push_back(c);
            end
            if ($urandom_range(9, 0) != 0) begin
               do c = 8'($urandom_range(255, 0)); while (char_value(c) < dmax);
               chars.push_back(c);
               if ($urandom_range(4, 0) == 0)
                  repeat ($urandom_range(2, 1)) chars.push_back(8'($urandom_range(255, 0)));
            end
         end
         foreach (chars[i])
            send_char(chars[i], i == 0,
                      (i == 0) ? b : stip_pkg::RADIX_W'($urandom_range(63, 0)));
      end
      wait_drained();
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_ignored_after_reset();
      test_number_forms();
      test_special_cases();
      test_saturation();
      test_backpressure();
      test_random_strings();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (expected_numbers.size() != 0) begin
         errors++;
         $display("%0t: results missing: expected %0d more, actual 0",
                  $time, expected_numbers.size());
      end
      $display("Run covered %0d strings, %0d requests (%0d parsed), %0d results checked",
               strings_sent, chars_sent, chars_parsed, results_checked);
      $display("(%0d saturated), with random gaps on both sides and a long result hold-off",
               saturated_results);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
